### src/voice_channel_replacement_assert.svh
// Assertion macros for the voice channel allocator.
// Defining NO_ASSERTIONS removes every check.
`ifndef VOICE_CHANNEL_REPLACEMENT_ASSERT_SVH
`define VOICE_CHANNEL_REPLACEMENT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcr: same-cycle check failed");
`define VCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vcr: next-cycle check failed");
`else
`define VCR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/vcr_pkg.sv
`timescale 1ns / 1ps

package vcr_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 32;

  localparam int unsigned ENT_W  = 11;
  localparam int unsigned SUB_W  = 8;
  localparam int unsigned NOW_W  = 31;
  localparam int unsigned DUR_W  = 24;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned CHAN_W = 5;
  localparam int unsigned TIME_W = 32;

  // Remaining time that no entry can beat; it seeds the least-time search.
  localparam logic [TIME_W-1:0] LIFE_START = 32'h7fff_ffff;

  localparam logic [ENT_W-1:0] LISTENER_RST = '1;

  typedef struct packed {
    logic signed [ENT_W-1:0] owner;
    logic [SUB_W-1:0]        sub;
    logic [TIME_W-1:0]       end_time;
  } vcr_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } vcr_state_e;

endpackage

### src/voice_channel_replacement.sv
// Allocate beat: the table is read one entry a cycle through the registered read port and
// each entry is judged after its read; a sub-channel hit ends the scan early. Release beat:
// goes straight to the commit. A new beat is taken only back in idle, once its result is registered.
// A stalled result holds the commit, and with it the input, until it is taken.
// Reset (rst_ni low, asynchronous) empties the whole table at once through its
// per-entry flags and sets the listener to -1; there is no clearing pass.
`timescale 1ns / 1ps
`include "voice_channel_replacement_assert.svh"

module voice_channel_replacement #(
  parameter int unsigned NUM_CHANNELS = vcr_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Listener register
  input  logic                              cfg_we_i,
  input  logic signed [vcr_pkg::ENT_W-1:0]  cfg_wdata_i,
  // Request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic signed [vcr_pkg::ENT_W-1:0]  entity_i,
  input  logic [vcr_pkg::SUB_W-1:0]         sub_channel_i,
  input  logic [vcr_pkg::NOW_W-1:0]         now_i,
  input  logic [vcr_pkg::DUR_W-1:0]         duration_i,
  input  logic [vcr_pkg::SLOT_W-1:0]        slot_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              granted_o,
  output logic [vcr_pkg::CHAN_W-1:0]        channel_o
);

  import vcr_pkg::*;

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_CHANNELS - 1);
  localparam logic [CntW-1:0] NumCh   = CntW'(NUM_CHANNELS);

  // Control state
  vcr_state_e state_q, state_d;
  logic signed [ENT_W-1:0] listener_q;
  logic [NUM_CHANNELS-1:0] valid_q, valid_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic ev_vld_q, ev_vld_d;
  logic pick_vld_q, pick_vld_d;
  logic out_valid_q, out_valid_d;

  // Request held for the duration of the scan
  logic func_q, func_d;
  logic signed [ENT_W-1:0] ent_q, ent_d;
  logic [SUB_W-1:0] sub_q, sub_d;
  logic [NOW_W-1:0] now_q, now_d;
  logic [DUR_W-1:0] dur_q, dur_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  // Scan bookkeeping and result
  logic [IdxW-1:0] ev_idx_q, ev_idx_d;
  logic [IdxW-1:0] pick_q, pick_d;
  logic [TIME_W-1:0] best_end_q, best_end_d;
  logic granted_q, granted_d;
  logic [CHAN_W-1:0] channel_q, channel_d;

  // The channel table: one synchronous memory with a registered read port. The
  // entry flags in valid_q double as the active marks; an entry whose flag is low
  // reads as the cleared value whatever the memory holds.
  vcr_entry_t mem_q [NUM_CHANNELS];
  vcr_entry_t rdata_q;
  logic rvalid_q;
  logic mem_we;
  vcr_entry_t mem_wdata;
  logic [IdxW-1:0] rd_addr;

  logic in_acc;
  logic out_free;
  logic slot_ok;

  // Entry under evaluation, with cleared entries folded in
  logic signed [ENT_W-1:0] e_own;
  logic [SUB_W-1:0] e_sub;
  logic [TIME_W-1:0] e_end;
  logic hit, skip, better, scan_done;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_ok  = 32'(slot_i) < 32'(NUM_CHANNELS);
  assign rd_addr  = rd_cnt_q[IdxW-1:0];

  // A sub-channel hit ends the scan at once. Otherwise active sounds of the
  // listener are protected from other requesters, and the least remaining time
  // wins. Comparing end times against a bound of now + LIFE_START is the same
  // as comparing remaining times, since now is fixed for the whole scan; the
  // strict compare keeps the lowest index on a tie.
  always_comb begin
    e_own     = rvalid_q ? rdata_q.owner    : '0;
    e_sub     = rvalid_q ? rdata_q.sub      : '0;
    e_end     = rvalid_q ? rdata_q.end_time : '0;
    hit       = (sub_q != '0) && (e_own == ent_q) && (e_sub == sub_q);
    skip      = rvalid_q && (e_own == listener_q) && (ent_q != listener_q);
    better    = !skip && (e_end < best_end_q);
    scan_done = ev_vld_q && (hit || (ev_idx_q == LastIdx));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = func_i ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and table updates
  always_comb begin
    func_d      = func_q;
    ent_d       = ent_q;
    sub_d       = sub_q;
    now_d       = now_q;
    dur_d       = dur_q;
    slot_d      = slot_q;
    rd_cnt_d    = rd_cnt_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = ev_idx_q;
    pick_d      = pick_q;
    pick_vld_d  = pick_vld_q;
    best_end_d  = best_end_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    granted_d   = granted_q;
    channel_d   = channel_q;
    mem_we      = 1'b0;
    mem_wdata   = '{owner: ent_q, sub: sub_q,
                    end_time: TIME_W'(now_q) + TIME_W'(dur_q)};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d     = func_i;
          ent_d      = entity_i;
          sub_d      = sub_channel_i;
          now_d      = now_i;
          dur_d      = duration_i;
          slot_d     = slot_i;
          rd_cnt_d   = '0;
          best_end_d = TIME_W'(now_i) + LIFE_START;
          pick_d     = IdxW'(slot_i);
          pick_vld_d = func_i && slot_ok;
        end
      end
      ST_SCAN: begin
        // One read is issued per cycle; the entry read last cycle is judged now.
        if (rd_cnt_q != NumCh) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
          ev_vld_d = 1'b1;
          ev_idx_d = rd_addr;
        end
        if (ev_vld_q) begin
          if (hit) begin
            pick_d     = ev_idx_q;
            pick_vld_d = 1'b1;
          end else if (better) begin
            best_end_d = e_end;
            pick_d     = ev_idx_q;
            pick_vld_d = 1'b1;
          end
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          granted_d   = pick_vld_q;
          if (func_q) begin
            channel_d = slot_q;
            if (pick_vld_q) begin
              valid_d[pick_q] = 1'b0;
            end
          end else begin
            channel_d = pick_vld_q ? CHAN_W'(pick_q) : '0;
            if (pick_vld_q) begin
              valid_d[pick_q] = 1'b1;
              mem_we          = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = out_valid_q;
    granted_o   = granted_q;
    channel_o   = channel_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      listener_q  <= LISTENER_RST;
      valid_q     <= '0;
      rd_cnt_q    <= '0;
      ev_vld_q    <= 1'b0;
      pick_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rd_cnt_q    <= rd_cnt_d;
      ev_vld_q    <= ev_vld_d;
      pick_vld_q  <= pick_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        listener_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    ent_q      <= ent_d;
    sub_q      <= sub_d;
    now_q      <= now_d;
    dur_q      <= dur_d;
    slot_q     <= slot_d;
    ev_idx_q   <= ev_idx_d;
    pick_q     <= pick_d;
    best_end_q <= best_end_d;
    granted_q  <= granted_d;
    channel_q  <= channel_d;
  end

  // Channel memory. Writes only happen in the commit cycle. The read port reads every cycle,
  // but only reads issued during a scan are judged, so a read that meets a write is never used.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[pick_q] <= mem_wdata;
    end
    rdata_q  <= mem_q[rd_addr];
    rvalid_q <= valid_q[rd_addr];
  end

  `VCR_ASSERT_NEXT(a_alloc_starts_scan, clk_i, rst_ni, in_acc && !func_i, (state_q == ST_SCAN) && (rd_cnt_q == '0))
  `VCR_ASSERT_IMP(a_eval_lags_read, clk_i, rst_ni, (state_q == ST_SCAN) && ev_vld_q, (CntW'(ev_idx_q) + CntW'(1)) == rd_cnt_q)
  `VCR_ASSERT_NEXT(a_commit_delivers, clk_i, rst_ni, (state_q == ST_COMMIT) && out_free, out_valid_q && (state_q == ST_IDLE))
  `VCR_ASSERT_NEXT(a_grant_marks_entry, clk_i, rst_ni, (state_q == ST_COMMIT) && out_free && !func_q && pick_vld_q, valid_q[$past(pick_q)])

endmodule
